/* design/utf8v_pkg.sv */
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and byte constants shared by the strict UTF-8 validator modules.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_E0,
    RULE_ED,
    RULE_F0,
    RULE_F4
  } rule_e;

  typedef struct packed {
    logic [1:0] cont_left;
    rule_e      rule;
    logic       err;
  } utf8v_state_t;

  localparam logic [7:0] ByteNul      = 8'h00;
  localparam logic [7:0] ByteAsciiMax = 8'h7f;
  localparam logic [7:0] ByteContMask = 8'hc0;
  localparam logic [7:0] ByteContTag  = 8'h80;
  localparam logic [7:0] ByteContMax  = 8'hbf;
  localparam logic [7:0] ByteLead2Min = 8'hc2;
  localparam logic [7:0] ByteLead2Max = 8'hdf;
  localparam logic [7:0] ByteLead3Min = 8'he0;
  localparam logic [7:0] ByteLead3Max = 8'hef;
  localparam logic [7:0] ByteLeadEd   = 8'hed;
  localparam logic [7:0] ByteLead4Min = 8'hf0;
  localparam logic [7:0] ByteLead4Max = 8'hf4;
  localparam logic [7:0] ByteE0SecMin = 8'ha0;
  localparam logic [7:0] ByteEdSecMax = 8'h9f;
  localparam logic [7:0] ByteF0SecMin = 8'h90;
  localparam logic [7:0] ByteF4SecMax = 8'h8f;

  localparam logic [1:0] ContNone = 2'd0;
  localparam logic [1:0] ContOne  = 2'd1;
  localparam logic [1:0] ContTwo  = 2'd2;
  localparam logic [1:0] ContThree = 2'd3;

  localparam utf8v_state_t StateClear = '{cont_left: ContNone, rule: RULE_NONE, err: 1'b0};

endpackage

/* design/utf8v_step.sv */
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state and verdict logic for one message byte of the validator.
// ----------------------------------------------------------------------------
module utf8v_step
  import utf8v_pkg::*;
(
  input  utf8v_state_t state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  input  logic         empty_message_i,
  output utf8v_state_t state_o,
  output logic         result_o,
  output logic         verdict_o
);

  utf8v_state_t upd;
  logic         cont_ok;

  always_comb begin
    unique case (state_i.rule)
      RULE_E0: cont_ok = (data_byte_i >= ByteE0SecMin) && (data_byte_i <= ByteContMax);
      RULE_ED: cont_ok = (data_byte_i >= ByteContTag) && (data_byte_i <= ByteEdSecMax);
      RULE_F0: cont_ok = (data_byte_i >= ByteF0SecMin) && (data_byte_i <= ByteContMax);
      RULE_F4: cont_ok = (data_byte_i >= ByteContTag) && (data_byte_i <= ByteF4SecMax);
      default: cont_ok = (data_byte_i & ByteContMask) == ByteContTag;
    endcase
  end

  always_comb begin
    upd = state_i;
    if (state_i.cont_left != ContNone) begin
      if (!cont_ok) begin
        upd.err = 1'b1;
      end
      upd.cont_left = state_i.cont_left - 2'd1;
      upd.rule      = RULE_NONE;
    end else begin
      upd.rule = RULE_NONE;
      priority if (data_byte_i == ByteNul) begin
        upd.err = 1'b1;
      end else if (data_byte_i <= ByteAsciiMax) begin
        upd.cont_left = ContNone;
      end else if ((data_byte_i >= ByteLead2Min) && (data_byte_i <= ByteLead2Max)) begin
        upd.cont_left = ContOne;
      end else if ((data_byte_i >= ByteLead3Min) && (data_byte_i <= ByteLead3Max)) begin
        upd.cont_left = ContTwo;
        if (data_byte_i == ByteLead3Min) begin
          upd.rule = RULE_E0;
        end else if (data_byte_i == ByteLeadEd) begin
          upd.rule = RULE_ED;
        end
      end else if ((data_byte_i >= ByteLead4Min) && (data_byte_i <= ByteLead4Max)) begin
        upd.cont_left = ContThree;
        if (data_byte_i == ByteLead4Min) begin
          upd.rule = RULE_F0;
        end else if (data_byte_i == ByteLead4Max) begin
          upd.rule = RULE_F4;
        end
      end else begin
        upd.err = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (empty_message_i) begin
      result_o  = 1'b1;
      verdict_o = 1'b1;
      state_o   = StateClear;
    end else if (last_byte_i) begin
      result_o  = 1'b1;
      verdict_o = !upd.err && (upd.cont_left == ContNone);
      state_o   = StateClear;
    end else begin
      result_o  = 1'b0;
      verdict_o = 1'b0;
      state_o   = upd;
    end
  end

endmodule

/* design/strict_utf8_validator.sv */
// ----------------------------------------------------------------------------
// strict_utf8_validator
// Checks a byte stream message by message against strict UTF-8 and reports
// one verdict word per message on its last byte or for an empty message.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o | data_byte_i, last_byte_i,
//           |           |                         | empty_message_i
//   out     | output    | out_valid_o/out_ready_i | message_valid_o
//
// One byte word is taken per cycle while in_ready_o is high; a verdict is
// presented once its final byte has passed the input register into the result register.
// The sequence state advances in a single step as each byte leaves the input
// register. Reset clears both valid flags and the sequence state at once.
// A stalled result holds only the input register's final byte; other bytes
// keep flowing, so the input stalls only once a second final byte reaches the
// input register while a verdict waits.
// ----------------------------------------------------------------------------
module strict_utf8_validator
  import utf8v_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       empty_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       message_valid_o
);

  logic         s1_valid_q;
  logic [7:0]   s1_byte_q;
  logic         s1_last_q;
  logic         s1_empty_q;
  utf8v_state_t state_q;
  utf8v_state_t state_d;
  logic         step_result;
  logic         step_verdict;
  logic         s1_adv;
  logic         out_valid_q;
  logic         verdict_q;

  utf8v_step u_step (
    .state_i         (state_q),
    .data_byte_i     (s1_byte_q),
    .last_byte_i     (s1_last_q),
    .empty_message_i (s1_empty_q),
    .state_o         (state_d),
    .result_o        (step_result),
    .verdict_o       (step_verdict)
  );

  assign s1_adv     = s1_valid_q && (!step_result || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_last_q  <= last_byte_i;
      s1_empty_q <= empty_message_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && step_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && step_result) begin
      verdict_q <= step_verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign message_valid_o = verdict_q;

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && step_result) |=> (state_q == StateClear))
    else $error("sequence state not cleared after a verdict");

  a_rule_needs_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.rule != RULE_NONE) |-> state_q.cont_left[1])
    else $error("second-byte rule active without a pending multi-byte sequence");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && step_result))
    else $error("verdict appeared without a final byte in the input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(verdict_q)))
    else $error("pending verdict was overwritten or dropped");

endmodule
